// ----- src/nsa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsa_pkg: shared types and constants of the note stack arpeggiator
// Action, result and register codes, reset values, pitch table and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package nsa_pkg;

	// input actions
	localparam logic [1:0] ACT_TICK = 2'd0;
	localparam logic [1:0] ACT_ON   = 2'd1;
	localparam logic [1:0] ACT_OFF  = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_FREQ  = 2'd0;
	localparam logic [1:0] KIND_START = 2'd1;
	localparam logic [1:0] KIND_STOP  = 2'd2;

	// register indexes
	localparam int          CFG_IDX_W      = 1;
	localparam int          CFG_DATA_W     = 16;
	localparam logic [0:0]  REG_ARP_VOICES = 1'b0;
	localparam logic [0:0]  REG_ARP_PERIOD = 1'b1;

	// defaults for the top level parameters
	localparam int NUM_VOICES_DEF  = 3;
	localparam int STACK_DEPTH_DEF = 8;
	localparam int TICK_RATE_DEF   = 1000000;

	localparam int           ARP_BITS       = 3;
	localparam logic [15:0]  ARP_PERIOD_RST = 16'd40000;
	localparam logic [15:0]  DIV_RST        = ARP_PERIOD_RST / 2;
	localparam logic [7:0]   NOTE_NONE      = 8'd255;

	// base increment width covers the slowest tick rate; shift adds up to 10 octaves
	localparam int BASE_W = 41;
	localparam int SH_W   = BASE_W + 10;

	typedef logic [20:0] freq_t;

	// pitch classes of octave 0 in Q16 Hz
	localparam freq_t FREQ_Q16 [12] = '{
		21'd1071616, 21'd1135340, 21'd1202848, 21'd1274378,
		21'd1350154, 21'd1430441, 21'd1515500, 21'd1605612,
		21'd1701089, 21'd1802240, 21'd1909407, 21'd2022948
	};

	typedef struct packed {
		logic       load_item;
		logic       div_dec;
		logic       div_reload;
		logic       div_one;
		logic       vi_clear;
		logic       vi_inc;
		logic       tick_read;
		logic       snd_update;
		logic       push_note;
		logic       off_clear;
		logic       off_read;
		logic       off_step;
		logic       off_commit;
		logic       emit;
		logic [1:0] emit_kind;
		logic       flush;
	} cmd_t;

	typedef struct packed {
		logic is_tick;
		logic is_on;
		logic is_off;
		logic cnt_zero;
		logic arp_sel;
		logic div_zero;
		logic snd_diff;
		logic vi_last;
		logic r_done;
		logic w_zero;
		logic pend_valid;
		logic out_free;
	} sts_t;

endpackage

// ----- src/nsa_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsa_ifs: channel interfaces of the note stack arpeggiator
// Input beat (action, voice, note) and result beat (kind, voice, word, last).
// ----------------------------------------------------------------------------
interface nsa_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [1:0] voice;
	logic [6:0] note;

	modport source (output valid, action, voice, note, input ready);
	modport sink (input valid, action, voice, note, output ready);
endinterface

interface nsa_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [1:0]  target_voice;
	logic [31:0] phase_increment;
	logic        last;

	modport source (output valid, kind, target_voice, phase_increment, last, input ready);
	modport sink (input valid, kind, target_voice, phase_increment, last, output ready);
endinterface

// ----- src/nsa_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsa_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module nsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- src/nsa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsa_ctrl: sequencer of the note stack arpeggiator
// Walks ticks over the voices, note-off compaction over the stack, and
// holds one result back so the final beat of an item carries last.
// ----------------------------------------------------------------------------
module nsa_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  nsa_pkg::sts_t sts,
	output nsa_pkg::cmd_t cmd
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_DECODE = 4'd1;
	localparam logic [3:0] ST_TVOICE = 4'd2;
	localparam logic [3:0] ST_TREAD  = 4'd3;
	localparam logic [3:0] ST_TWORD  = 4'd4;
	localparam logic [3:0] ST_TNEXT  = 4'd5;
	localparam logic [3:0] ST_NON    = 4'd6;
	localparam logic [3:0] ST_ORD    = 4'd7;
	localparam logic [3:0] ST_OCMP   = 4'd8;
	localparam logic [3:0] ST_OEND   = 4'd9;
	localparam logic [3:0] ST_FIN    = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (sts.is_tick) begin
					cmd.div_dec  = 1'b1;
					cmd.vi_clear = 1'b1;
					state_d      = ST_TVOICE;
				end else if (sts.is_on) begin
					state_d = ST_NON;
				end else if (sts.is_off) begin
					cmd.off_clear = 1'b1;
					state_d       = ST_ORD;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_TVOICE: begin
				if (sts.cnt_zero || (sts.arp_sel && !sts.div_zero)) begin
					state_d = ST_TNEXT;
				end else begin
					cmd.tick_read = 1'b1;
					state_d       = ST_TREAD;
				end
			end
			ST_TREAD: begin
				if (sts.arp_sel || sts.snd_diff) begin
					cmd.snd_update = 1'b1;
					state_d        = ST_TWORD;
				end else begin
					state_d = ST_TNEXT;
				end
			end
			ST_TWORD: begin
				if (!sts.pend_valid || sts.out_free) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = nsa_pkg::KIND_FREQ;
					state_d       = ST_TNEXT;
				end
			end
			ST_TNEXT: begin
				if (sts.vi_last) begin
					cmd.div_reload = sts.div_zero;
					state_d        = ST_FIN;
				end else begin
					cmd.vi_inc = 1'b1;
					state_d    = ST_TVOICE;
				end
			end
			ST_NON: begin
				cmd.push_note = 1'b1;
				cmd.emit      = 1'b1;
				cmd.emit_kind = nsa_pkg::KIND_START;
				state_d       = ST_FIN;
			end
			ST_ORD: begin
				if (sts.r_done) begin
					state_d = ST_OEND;
				end else begin
					cmd.off_read = 1'b1;
					state_d      = ST_OCMP;
				end
			end
			ST_OCMP: begin
				cmd.off_step = 1'b1;
				state_d      = ST_ORD;
			end
			ST_OEND: begin
				cmd.off_commit = 1'b1;
				cmd.div_one    = 1'b1;
				if (sts.w_zero) begin
					cmd.emit      = 1'b1;
					cmd.emit_kind = nsa_pkg::KIND_STOP;
				end
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!sts.pend_valid) begin
					state_d = ST_IDLE;
				end else if (sts.out_free) begin
					cmd.flush = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- src/nsa_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsa_dp: datapath of the note stack arpeggiator
// Note stacks in RAM, per-voice counts and positions, step divider,
// config registers, pitch word unit, pending and output result registers.
// ----------------------------------------------------------------------------
module nsa_dp #(
	parameter int NUM_VOICES  = nsa_pkg::NUM_VOICES_DEF,
	parameter int STACK_DEPTH = nsa_pkg::STACK_DEPTH_DEF,
	parameter int TICK_RATE   = nsa_pkg::TICK_RATE_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  nsa_pkg::cmd_t                       cmd,
	output nsa_pkg::sts_t                       sts,
	input  logic                                cfg_wen,
	input  logic [nsa_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [nsa_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [1:0]                          in_action,
	input  logic [1:0]                          in_voice,
	input  logic [6:0]                          in_note,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [1:0]                          out_kind,
	output logic [1:0]                          out_voice,
	output logic [31:0]                         out_word,
	output logic                                out_last
);

	localparam int VI_W    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
	localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
	localparam int ENTRIES = NUM_VOICES * STACK_DEPTH;
	localparam int ADDR_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	// item
	logic [1:0] action_q;
	logic [1:0] voice_q;
	logic [6:0] note_q;

	// per-voice state
	logic [CNT_W-1:0] cnt_q [NUM_VOICES];
	logic [CNT_W-1:0] pos_q [NUM_VOICES];
	logic [7:0]       snd_q [NUM_VOICES];

	logic [15:0]                  div_q;
	logic [nsa_pkg::ARP_BITS-1:0] arp_voices_q;
	logic [15:0]                  arp_period_q;

	logic [VI_W-1:0]  vi_q;
	logic [CNT_W-1:0] r_q;
	logic [CNT_W-1:0] w_q;
	logic [6:0]       wnote_q;

	logic        pend_valid_q;
	logic [1:0]  pend_kind_q;
	logic [1:0]  pend_voice_q;
	logic [31:0] pend_word_q;

	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [1:0]  out_voice_q;
	logic [31:0] out_word_q;
	logic        out_last_q;

	logic [NUM_VOICES-1:0] arp_mask;
	logic [CNT_W-1:0]      cur_cnt;
	logic [CNT_W-1:0]      cur_pos;
	logic [CNT_W-1:0]      pos_fix;
	logic                  cnt_full;
	logic                  voice_ok;
	logic                  keep;
	logic [ADDR_W-1:0]     vbase;
	logic [ADDR_W-1:0]     raddr;
	logic [ADDR_W-1:0]     waddr;
	logic                  we;
	logic [6:0]            wdata;
	logic [6:0]            rd_data;
	logic                  out_free;

	// pitch word
	logic [nsa_pkg::BASE_W-1:0] base_tbl [12];
	logic [12:0]                oct_prod;
	logic [3:0]                 oct;
	logic [6:0]                 oct12;
	logic [6:0]                 pc_full;
	logic [nsa_pkg::SH_W-1:0]   shifted;
	logic [31:0]                word;

	for (genvar g = 0; g < 12; g++) begin : g_base
		assign base_tbl[g] = nsa_pkg::BASE_W'(
			(64'(nsa_pkg::FREQ_Q16[g]) << 32) / 64'(TICK_RATE));
	end

	for (genvar g = 0; g < NUM_VOICES; g++) begin : g_arp
		if (g < nsa_pkg::ARP_BITS) begin : g_bit
			assign arp_mask[g] = arp_voices_q[g];
		end else begin : g_none
			assign arp_mask[g] = 1'b0;
		end
	end

	nsa_ram #(
		.WIDTH (7),
		.DEPTH (ENTRIES)
	) u_stack_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd_data)
	);

	assign cur_cnt  = cnt_q[vi_q];
	assign cur_pos  = pos_q[vi_q];
	assign pos_fix  = (cur_pos >= cur_cnt) ? '0 : cur_pos;
	assign cnt_full = (cur_cnt >= CNT_W'(STACK_DEPTH));
	assign voice_ok = ({30'd0, voice_q} < 32'(NUM_VOICES));
	assign keep     = (rd_data != note_q);
	assign vbase    = ADDR_W'(vi_q) * ADDR_W'(STACK_DEPTH);
	assign raddr    = cmd.off_read ?
		vbase + ADDR_W'(r_q) : vbase + ADDR_W'(arp_mask[vi_q] ? pos_fix : '0);
	assign waddr    = cmd.push_note ? vbase + ADDR_W'(cur_cnt) : vbase + ADDR_W'(w_q);
	assign we       = (cmd.push_note && !cnt_full) || (cmd.off_step && keep);
	assign wdata    = cmd.push_note ? note_q : rd_data;
	assign out_free = !out_valid_q || out_ready;

	// note / 12 by reciprocal (43/512 is exact for 7-bit notes)
	assign oct_prod = 13'(wnote_q) * 13'd43;
	assign oct      = oct_prod[12:9];
	assign oct12    = 7'({oct, 3'b000}) + 7'({oct, 2'b00});
	assign pc_full  = wnote_q - oct12;
	assign shifted  = nsa_pkg::SH_W'(base_tbl[pc_full[3:0]]) << oct;
	assign word     = (|shifted[nsa_pkg::SH_W-1:48]) ? '1 : shifted[47:16];

	always_comb begin
		sts            = '0;
		sts.is_tick    = (action_q == nsa_pkg::ACT_TICK);
		sts.is_on      = (action_q == nsa_pkg::ACT_ON) && voice_ok;
		sts.is_off     = (action_q == nsa_pkg::ACT_OFF) && voice_ok;
		sts.cnt_zero   = (cur_cnt == '0);
		sts.arp_sel    = arp_mask[vi_q];
		sts.div_zero   = (div_q == '0);
		sts.snd_diff   = (snd_q[vi_q] != {1'b0, rd_data});
		sts.vi_last    = (vi_q == VI_W'(NUM_VOICES - 1));
		sts.r_done     = (r_q == cur_cnt);
		sts.w_zero     = (w_q == '0);
		sts.pend_valid = pend_valid_q;
		sts.out_free   = out_free;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_VOICES; i++) begin
				cnt_q[i] <= '0;
				pos_q[i] <= '0;
				snd_q[i] <= nsa_pkg::NOTE_NONE;
			end
			div_q        <= nsa_pkg::DIV_RST;
			arp_voices_q <= '0;
			arp_period_q <= nsa_pkg::ARP_PERIOD_RST;
			vi_q         <= '0;
			r_q          <= '0;
			w_q          <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					nsa_pkg::REG_ARP_VOICES: arp_voices_q <= cfg_data[nsa_pkg::ARP_BITS-1:0];
					nsa_pkg::REG_ARP_PERIOD: arp_period_q <= cfg_data;
					default: ;
				endcase
			end

			if (cmd.load_item) begin
				vi_q <= VI_W'(in_voice);
			end else if (cmd.vi_clear) begin
				vi_q <= '0;
			end else if (cmd.vi_inc) begin
				vi_q <= vi_q + 1'b1;
			end

			if (cmd.div_dec) begin
				div_q <= div_q - 16'd1;
			end else if (cmd.div_reload) begin
				div_q <= arp_period_q;
			end else if (cmd.div_one) begin
				div_q <= 16'd1;
			end

			if (cmd.tick_read && arp_mask[vi_q]) begin
				pos_q[vi_q] <= pos_fix + 1'b1;
			end
			if (cmd.snd_update) begin
				snd_q[vi_q] <= {1'b0, rd_data};
			end

			if (cmd.push_note && !cnt_full) begin
				cnt_q[vi_q] <= cur_cnt + 1'b1;
			end else if (cmd.off_commit) begin
				cnt_q[vi_q] <= w_q;
			end

			if (cmd.off_clear) begin
				r_q <= '0;
				w_q <= '0;
			end else if (cmd.off_step) begin
				r_q <= r_q + 1'b1;
				if (keep) begin
					w_q <= w_q + 1'b1;
				end
			end

			if (cmd.emit) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_valid_q <= 1'b0;
			end

			if ((cmd.emit || cmd.flush) && pend_valid_q) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			action_q <= in_action;
			voice_q  <= in_voice;
			note_q   <= in_note;
		end
		if (cmd.snd_update) begin
			wnote_q <= rd_data;
		end
		if (cmd.emit) begin
			pend_kind_q  <= cmd.emit_kind;
			pend_voice_q <= 2'(vi_q);
			pend_word_q  <= (cmd.emit_kind == nsa_pkg::KIND_FREQ) ? word : '0;
		end
		if ((cmd.emit || cmd.flush) && pend_valid_q) begin
			out_kind_q  <= pend_kind_q;
			out_voice_q <= pend_voice_q;
			out_word_q  <= pend_word_q;
			out_last_q  <= cmd.flush;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_voice = out_voice_q;
	assign out_word  = out_word_q;
	assign out_last  = out_last_q;

endmodule

// ----- src/note_stack_arpeggiator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// note_stack_arpeggiator: held-note stacks, arpeggiator and pitch words
// Top level: joins the sequencer and the datapath to the beat channels.
// ----------------------------------------------------------------------------
// Flow from beat taken to final result valid: note on DECODE, NON, FIN; note
//   off ORD and OCMP per held note, then OEND, FIN; tick each voice through
//   TVOICE, TREAD on a note read (registered RAM read port), TWORD on a new
//   word, TNEXT, then FIN. One item at a time; the next beat is taken in the
//   cycle after the final result is loaded, and output stalls add directly.
// Reset: arst_n clears counts, positions, divider, config and both result
//   registers at once; stack RAM contents are left as they are.
module note_stack_arpeggiator #(
	parameter int NUM_VOICES  = nsa_pkg::NUM_VOICES_DEF,
	parameter int STACK_DEPTH = nsa_pkg::STACK_DEPTH_DEF,
	parameter int TICK_RATE   = nsa_pkg::TICK_RATE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	nsa_in_if.sink                          item,
	nsa_out_if.source                       result,
	input  logic                            cfg_wen,
	input  logic [nsa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [nsa_pkg::CFG_DATA_W-1:0]  cfg_data
);

	nsa_pkg::cmd_t cmd;
	nsa_pkg::sts_t sts;
	logic          in_ready;

	// sequencer: IDLE takes a beat, then walks the item to its last result
	nsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	assign item.ready = in_ready;

	// datapath: one result held back in a pending slot so the last flag is
	// known before the beat leaves through the output register
	nsa_dp #(
		.NUM_VOICES  (NUM_VOICES),
		.STACK_DEPTH (STACK_DEPTH),
		.TICK_RATE   (TICK_RATE)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_action (item.action),
		.in_voice  (item.voice),
		.in_note   (item.note),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_kind  (result.kind),
		.out_voice (result.target_voice),
		.out_word  (result.phase_increment),
		.out_last  (result.last)
	);

endmodule

// ----- src/nsa_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsa_checker: port-level checks of the note stack arpeggiator
// Result beat holding and sequencing against input acceptance.
// ----------------------------------------------------------------------------
module nsa_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  out_kind,
	input logic [1:0]  out_voice,
	input logic [31:0] out_word,
	input logic        out_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_kind) && $stable(out_voice)
			&& $stable(out_word) && $stable(out_last))
		else $error("result payload changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second beat taken while an item is in work");

	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without an item in work");

endmodule

bind note_stack_arpeggiator nsa_checker u_nsa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_kind  (result.kind),
	.out_voice (result.target_voice),
	.out_word  (result.phase_increment),
	.out_last  (result.last)
);

// ----- dv/nsa_event_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsa_event_checker: scoreboard for the note stack arpeggiator
// Watches the item, result and register ports, keeps its own copy of the
// held-note stacks and divider, and checks every result beat in order.
// ----------------------------------------------------------------------------
module nsa_event_checker #(
	parameter int NUM_VOICES  = nsa_pkg::NUM_VOICES_DEF,
	parameter int STACK_DEPTH = nsa_pkg::STACK_DEPTH_DEF,
	parameter int TICK_RATE   = nsa_pkg::TICK_RATE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	nsa_in_if                               item_mon,
	nsa_out_if                              result_mon,
	input  logic                            cfg_wen,
	input  logic [nsa_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [nsa_pkg::CFG_DATA_W-1:0]  cfg_data,
	output int                              mismatch_count,
	output int                              pending_count,
	output int                              items_seen,
	output int                              results_seen
);

	localparam int MAX_SHOWN = 10;

	// octave-0 pitch classes, Q16 Hz
	localparam logic [63:0] PITCH_Q16 [12] = '{
		64'd1071616, 64'd1135340, 64'd1202848, 64'd1274378,
		64'd1350154, 64'd1430441, 64'd1515500, 64'd1605612,
		64'd1701089, 64'd1802240, 64'd1909407, 64'd2022948
	};

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  voice;
		logic [31:0] word;
		logic        last;
	} note_event_t;

	note_event_t pending_events [$];
	note_event_t got, want;

	logic [6:0]  held_notes [NUM_VOICES][STACK_DEPTH];
	logic [3:0]  held_count [NUM_VOICES];
	logic [3:0]  arp_step [NUM_VOICES];
	logic [7:0]  playing_note [NUM_VOICES];
	logic [15:0] step_count;
	logic [2:0]  arp_mask;
	logic [15:0] step_reload;

	function automatic logic [31:0] pitch_word(input logic [6:0] note);
		logic [63:0] base;
		logic [63:0] w;
		int          pc;
		int          oct;
		pc   = int'(note) % 12;
		oct  = int'(note) / 12;
		base = (PITCH_Q16[pc] << 32) / 64'(TICK_RATE);
		w    = (base << oct) >> 16;
		if (w > 64'hFFFF_FFFF)
			w = 64'hFFFF_FFFF;
		return w[31:0];
	endfunction

	function automatic note_event_t make_event(input logic [1:0] kind, input int v,
		input logic [31:0] word);
		note_event_t ev;
		ev.kind  = kind;
		ev.voice = 2'(v);
		ev.word  = word;
		ev.last  = 1'b0;
		return ev;
	endfunction

	task automatic clear_stacks();
		for (int i = 0; i < NUM_VOICES; i++) begin
			for (int j = 0; j < STACK_DEPTH; j++)
				held_notes[i][j] = '0;
			held_count[i]   = '0;
			arp_step[i]     = '0;
			playing_note[i] = nsa_pkg::NOTE_NONE;
		end
		step_count  = nsa_pkg::DIV_RST;
		arp_mask    = '0;
		step_reload = nsa_pkg::ARP_PERIOD_RST;
		pending_events.delete();
	endtask

	// works out the result beats of one accepted item and queues them
	task automatic predict_events(input logic [1:0] act, input logic [1:0] v,
		input logic [6:0] note);
		note_event_t batch [$];
		note_event_t ev;
		logic        arp;
		int          cnt;
		int          w;
		case (act)
			nsa_pkg::ACT_TICK: begin
				step_count = step_count - 16'd1;
				for (int i = 0; i < NUM_VOICES; i++) begin
					arp = (i < nsa_pkg::ARP_BITS) ? arp_mask[i] : 1'b0;
					if (held_count[i] != 0) begin
						if (arp) begin
							if (step_count == 0) begin
								if (arp_step[i] >= held_count[i])
									arp_step[i] = '0;
								playing_note[i] = {1'b0, held_notes[i][arp_step[i]]};
								batch.push_back(make_event(nsa_pkg::KIND_FREQ, i,
									pitch_word(playing_note[i][6:0])));
								arp_step[i] = arp_step[i] + 4'd1;
							end
						end else if (playing_note[i] != {1'b0, held_notes[i][0]}) begin
							playing_note[i] = {1'b0, held_notes[i][0]};
							batch.push_back(make_event(nsa_pkg::KIND_FREQ, i,
								pitch_word(playing_note[i][6:0])));
						end
					end
				end
				if (step_count == 0)
					step_count = step_reload;
			end
			nsa_pkg::ACT_ON: begin
				if (int'(v) < NUM_VOICES) begin
					if (int'(held_count[v]) < STACK_DEPTH) begin
						held_notes[v][held_count[v]] = note;
						held_count[v] = held_count[v] + 4'd1;
					end
					batch.push_back(make_event(nsa_pkg::KIND_START, int'(v), '0));
				end
			end
			nsa_pkg::ACT_OFF: begin
				if (int'(v) < NUM_VOICES) begin
					cnt = int'(held_count[v]);
					if (cnt > STACK_DEPTH)
						cnt = STACK_DEPTH;
					w = 0;
					// remove every copy, no element skipped after a shift
					for (int r = 0; r < cnt; r++) begin
						if (held_notes[v][r] != note) begin
							held_notes[v][w] = held_notes[v][r];
							w++;
						end
					end
					held_count[v] = 4'(w);
					if (w == 0)
						batch.push_back(make_event(nsa_pkg::KIND_STOP, int'(v), '0));
					step_count = 16'd1;
				end
			end
			default: ;
		endcase
		for (int k = 0; k < batch.size(); k++) begin
			ev      = batch[k];
			ev.last = (k == batch.size() - 1);
			pending_events.push_back(ev);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_stacks();
			mismatch_count = 0;
			pending_count  = 0;
			items_seen     = 0;
			results_seen   = 0;
		end else begin
			if (cfg_wen) begin
				if (cfg_index == nsa_pkg::REG_ARP_VOICES)
					arp_mask = cfg_data[2:0];
				else if (cfg_index == nsa_pkg::REG_ARP_PERIOD)
					step_reload = cfg_data[15:0];
			end
			if (result_mon.valid && result_mon.ready) begin
				results_seen++;
				got.kind  = result_mon.kind;
				got.voice = result_mon.target_voice;
				got.word  = result_mon.phase_increment;
				got.last  = result_mon.last;
				if (pending_events.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_SHOWN)
						$display("%0t unexpected result beat: kind=%0d voice=%0d word=%h last=%0d",
							$realtime, got.kind, got.voice, got.word, got.last);
				end else begin
					want = pending_events.pop_front();
					if (got !== want) begin
						mismatch_count++;
						if (mismatch_count <= MAX_SHOWN)
							$display({"%0t result mismatch: exp kind=%0d voice=%0d word=%h",
								" last=%0d, got kind=%0d voice=%0d word=%h last=%0d"},
								$realtime, want.kind, want.voice, want.word, want.last,
								got.kind, got.voice, got.word, got.last);
					end
				end
			end
			if (item_mon.valid && item_mon.ready) begin
				items_seen++;
				predict_events(item_mon.action, item_mon.voice, item_mon.note);
			end
			pending_count = pending_events.size();
		end
	end

endmodule

// ----- dv/tb_note_stack_arpeggiator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_note_stack_arpeggiator: testbench top of the note stack arpeggiator
// Drives note on, note off and tick beats plus register writes, with random
// gaps on both channels; the event checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_note_stack_arpeggiator;

	// codes the package leaves unnamed: the spare action and a voice past the bank
	localparam logic [1:0] ACT_SPARE   = 2'd3;
	localparam logic [1:0] VOICE_EXTRA = 2'd3;

	localparam int IDLE_PCT      = 38;    // chance of a gap cycle, either side
	localparam int SETTLE_CYCLES = 40;    // covers the longest note off walk
	localparam int STALL_LIMIT   = 2000;  // cycles with no beat at all
	localparam int PHASE_ITEMS   = 70;    // counted random beats per setting
	localparam int NUM_PHASES    = 6;
	localparam int CALM_PHASE    = 2;     // both sides run with no gaps here

	// register settings walked in order: period 1 steps every tick, period 0
	// wraps the divider and is the slowest, the last one restores reset
	localparam logic [2:0]  PHASE_VOICES [NUM_PHASES] = '{
		3'd7, 3'd5, 3'd2, 3'd3, 3'd6, 3'd0
	};
	localparam logic [15:0] PHASE_PERIOD [NUM_PHASES] = '{
		16'd1, 16'd0, 16'd3, 16'hFFFF, 16'd2, 16'd40000
	};

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_wen;
	logic [nsa_pkg::CFG_IDX_W-1:0]   cfg_index;
	logic [nsa_pkg::CFG_DATA_W-1:0]  cfg_data;
	logic                            no_idling;
	logic [6:0]                      note_pool [4];

	int mismatch_count;
	int pending_count;
	int items_seen;
	int results_seen;
	int stall_cycles;
	int fail_total;

	nsa_in_if  item_ch ();
	nsa_out_if result_ch ();

	note_stack_arpeggiator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	nsa_event_checker chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_mon       (item_ch),
		.result_mon     (result_ch),
		.cfg_wen        (cfg_wen),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count),
		.items_seen     (items_seen),
		.results_seen   (results_seen)
	);

	// 12 ns period
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// result side back-pressure, changed only at falling edges
	always @(negedge clk) begin
		result_ch.ready <= no_idling || ($urandom_range(99) >= IDLE_PCT);
	end

	// watchdog: any beat on either channel restarts the count
	always @(posedge clk) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((item_ch.valid && item_ch.ready) ||
			(result_ch.valid && result_ch.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("watchdog: no beat for %0d cycles, %0d results still due",
					STALL_LIMIT, pending_count);
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Entered and left at a falling edge. Gap cycles come first so that valid
	// stays high across back-to-back beats and is never lowered and raised in
	// the same step.
	task automatic send_beat(input logic [1:0] act, input logic [1:0] v,
		input logic [6:0] n);
		while (!no_idling && $urandom_range(99) < IDLE_PCT) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid  <= 1'b1;
		item_ch.action <= act;
		item_ch.voice  <= v;
		item_ch.note   <= n;
		do
			@(posedge clk);
		while (!item_ch.ready);
		@(negedge clk);
	endtask

	// one write strobe, then cfg_wen is held low so back-to-back writes never
	// lower and raise cfg_wen in the same step
	task automatic write_reg(input logic [nsa_pkg::CFG_IDX_W-1:0] idx,
		input logic [nsa_pkg::CFG_DATA_W-1:0] data);
		cfg_wen   <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(negedge clk);
		cfg_wen <= 1'b0;
		@(negedge clk);
	endtask

	// stop sending, let every predicted result drain, then give the block
	// time to finish items that produce nothing (off with notes left, etc.)
	task automatic settle_block();
		item_ch.valid <= 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Mostly well-formed traffic drawn from a small note pool so that note
	// offs hit held notes and copies pile up; a few beats are spare actions
	// or voices past the bank, which the block must ignore.
	task automatic random_beat(output bit counted);
		int         pick;
		logic [1:0] act;
		logic [1:0] v;
		logic [6:0] n;
		pick    = $urandom_range(99);
		n       = ($urandom_range(3) == 0) ? 7'($urandom_range(127))
			: note_pool[$urandom_range(3)];
		v       = 2'($urandom_range(2));
		counted = 1'b1;
		if (pick < 45) begin
			act = nsa_pkg::ACT_TICK;
			v   = 2'($urandom);    // ignored by a tick, toggled anyway
		end else if (pick < 75) begin
			act = nsa_pkg::ACT_ON;
		end else if (pick < 95) begin
			act = nsa_pkg::ACT_OFF;
		end else begin
			counted = 1'b0;
			if ($urandom_range(1) == 0) begin
				act = ACT_SPARE;
				v   = 2'($urandom);
			end else begin
				act = ($urandom_range(1) == 0) ? nsa_pkg::ACT_ON : nsa_pkg::ACT_OFF;
				v   = VOICE_EXTRA;
			end
		end
		send_beat(act, v, n);
	endtask

	initial begin
		int done;
		bit counted;

		// every block input known from time zero
		arst_n           = 1'b0;
		cfg_wen          = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		item_ch.valid    = 1'b0;
		item_ch.action   = nsa_pkg::ACT_TICK;
		item_ch.voice    = '0;
		item_ch.note     = '0;
		result_ch.ready  = 1'b0;
		no_idling        = 1'b0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// ---- directed, reset settings: no voice in arpeggio mode ----
		send_beat(nsa_pkg::ACT_TICK, 2'd0, 7'd0);        // tick over empty stacks
		send_beat(ACT_SPARE, 2'd1, 7'd77);               // unused action
		send_beat(nsa_pkg::ACT_ON, VOICE_EXTRA, 7'd10);  // voice past the bank
		send_beat(nsa_pkg::ACT_OFF, VOICE_EXTRA, 7'd10);
		send_beat(nsa_pkg::ACT_ON, 2'd0, 7'd0);          // lowest note
		send_beat(nsa_pkg::ACT_ON, 2'd0, 7'd127);        // highest note
		send_beat(nsa_pkg::ACT_TICK, 2'd3, 7'd127);      // voice 0 picks up its oldest note
		// fill voice 1 with runs of one note, then one more to overflow the stack
		send_beat(nsa_pkg::ACT_ON, 2'd1, 7'd60);
		send_beat(nsa_pkg::ACT_ON, 2'd1, 7'd60);
		send_beat(nsa_pkg::ACT_ON, 2'd1, 7'd61);
		send_beat(nsa_pkg::ACT_ON, 2'd1, 7'd60);
		send_beat(nsa_pkg::ACT_ON, 2'd1, 7'd60);
		send_beat(nsa_pkg::ACT_ON, 2'd1, 7'd62);
		send_beat(nsa_pkg::ACT_ON, 2'd1, 7'd60);
		send_beat(nsa_pkg::ACT_ON, 2'd1, 7'd60);
		send_beat(nsa_pkg::ACT_ON, 2'd1, 7'd63);         // dropped, start still reported
		send_beat(nsa_pkg::ACT_TICK, 2'd0, 7'd0);
		send_beat(nsa_pkg::ACT_OFF, 2'd1, 7'd5);         // note not held
		send_beat(nsa_pkg::ACT_OFF, 2'd1, 7'd60);        // adjacent copies all go
		send_beat(nsa_pkg::ACT_TICK, 2'd0, 7'd0);        // oldest note of voice 1 moved
		send_beat(nsa_pkg::ACT_OFF, 2'd0, 7'd0);
		send_beat(nsa_pkg::ACT_TICK, 2'd0, 7'd0);
		send_beat(nsa_pkg::ACT_OFF, 2'd1, 7'd61);
		send_beat(nsa_pkg::ACT_OFF, 2'd1, 7'd62);        // stack empties: envelope stop
		send_beat(nsa_pkg::ACT_ON, 2'd2, 7'd127);

		// ---- random traffic under each register setting ----
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			settle_block();
			// spare data bits above the voice mask are toggled too
			write_reg(nsa_pkg::REG_ARP_VOICES, {13'($urandom), PHASE_VOICES[ph]});
			write_reg(nsa_pkg::REG_ARP_PERIOD, PHASE_PERIOD[ph]);
			for (int k = 0; k < 4; k++)
				note_pool[k] = 7'($urandom_range(127));
			no_idling = (ph == CALM_PHASE);
			done = 0;
			while (done < PHASE_ITEMS) begin
				random_beat(counted);
				if (counted)
					done++;
			end
			no_idling = 1'b0;
		end

		// drain and allow late beats to show up as unexpected
		settle_block();
		fail_total = mismatch_count + pending_count;

		$display("covered %0d input beats under %0d register settings, %0d result beats checked",
			items_seen, NUM_PHASES, results_seen);
		$display("mismatches %0d, results never delivered %0d", mismatch_count, pending_count);
		if (fail_total == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ----- note_stack_arpeggiator.f -----
src/nsa_pkg.sv
src/nsa_ifs.sv
src/nsa_ram.sv
src/nsa_ctrl.sv
src/nsa_dp.sv
src/note_stack_arpeggiator.sv
src/nsa_checker.sv
dv/nsa_event_checker.sv
dv/tb_note_stack_arpeggiator.sv
